// ===== rtl/hrt_pkg.sv =====
// Shared types, constants and match tables for the HTTP response head tokenizer.
package hrt_pkg;

    localparam int LEN_W = 32;
    localparam int LEN_ACC_W = LEN_W + 4;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TDATA_USED = 8 + 2 + LEN_W + 1 + 2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [4:0] STAT_POS_MAX = 5'd31;
    localparam logic [3:0] NAME_POS_MAX = 4'd15;
    localparam logic [3:0] NAME_LEN = 4'd14;

    localparam logic [4:0] STAT_LEN0 = 5'd6;
    localparam logic [4:0] STAT_LEN1 = 5'd6;
    localparam logic [4:0] STAT_LEN2 = 5'd13;
    localparam logic [4:0] STAT_LEN3 = 5'd25;

    localparam logic [6*8-1:0] STAT_TXT0 = "200 OK";
    localparam logic [6*8-1:0] STAT_TXT1 = "200 Ok";
    localparam logic [13*8-1:0] STAT_TXT2 = "404 Not Found";
    localparam logic [25*8-1:0] STAT_TXT3 = "500 Internal Server Error";
    localparam logic [14*8-1:0] NAME_TXT = "content-length";

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_OK = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_SERVER_ERR = 2'd3;

    typedef enum logic [10:0] {
        PH_VERSION   = 11'b000_0000_0001,
        PH_STATUS    = 11'b000_0000_0010,
        PH_STATUS_LF = 11'b000_0000_0100,
        PH_LINE_ST   = 11'b000_0000_1000,
        PH_NAME      = 11'b000_0001_0000,
        PH_VALUE     = 11'b000_0010_0000,
        PH_HEADER_LF = 11'b000_0100_0000,
        PH_BLANK_LF  = 11'b000_1000_0000,
        PH_BODY      = 11'b001_0000_0000,
        PH_DONE      = 11'b010_0000_0000,
        PH_ERROR     = 11'b100_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        DA_IDLE = 3'b001,
        DA_WAIT = 3'b010,
        DA_IN   = 3'b100
    } digits_t;

    typedef enum logic [2:0] {
        K_VERSION = 3'd0,
        K_STATUS  = 3'd1,
        K_NAME    = 3'd2,
        K_VALUE   = 3'd3,
        K_DELIM   = 3'd4,
        K_BODY    = 3'd5,
        K_IGNORED = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_NO_LF  = 2'd1,
        ERR_NAME   = 2'd2,
        ERR_STATUS = 2'd3
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         char_out;
        logic [1:0]         status;
        logic [LEN_W-1:0]   length;
        logic               head_done;
        logic               body_last;
        err_t               error;
    } hrt_result_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                r = c + CASE_OFFSET;
            end
            return r;
        end
    endfunction

    function automatic logic status_hit(input logic [1:0] idx, input logic [4:0] pos,
                                        input logic [7:0] c);
        logic hit;
        begin
            hit = 1'b0;
            unique case (idx)
                2'd0: if (pos < STAT_LEN0) begin
                    hit = (STAT_TXT0[(5 - 32'(pos)) * 8 +: 8] == c);
                end
                2'd1: if (pos < STAT_LEN1) begin
                    hit = (STAT_TXT1[(5 - 32'(pos)) * 8 +: 8] == c);
                end
                2'd2: if (pos < STAT_LEN2) begin
                    hit = (STAT_TXT2[(12 - 32'(pos)) * 8 +: 8] == c);
                end
                2'd3: if (pos < STAT_LEN3) begin
                    hit = (STAT_TXT3[(24 - 32'(pos)) * 8 +: 8] == c);
                end
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    function automatic logic name_hit(input logic [3:0] pos, input logic [7:0] c);
        logic hit;
        begin
            hit = 1'b0;
            if (pos < NAME_LEN) begin
                hit = (NAME_TXT[(13 - 32'(pos)) * 8 +: 8] == c);
            end
            return hit;
        end
    endfunction

endpackage

// ===== rtl/hrt_len_acc.sv =====
// Saturating decimal accumulate: value * 10 + digit, clamped to the all-ones value.
module hrt_len_acc import hrt_pkg::*; (
    input  logic [LEN_W-1:0] len_in,
    input  logic [3:0]       digit,
    output logic [LEN_W-1:0] len_out
);

    logic [LEN_ACC_W-1:0] wide;

    assign wide = ({4'b0000, len_in} << 3) + ({4'b0000, len_in} << 1)
                + {{(LEN_ACC_W-4){1'b0}}, digit};

    assign len_out = (wide[LEN_ACC_W-1:LEN_W] != 4'b0000) ? {LEN_W{1'b1}}
                                                          : wide[LEN_W-1:0];

endmodule

// ===== rtl/hrt_core.sv =====
// Parser state registers and per-byte tagging, status match and length decode.
module hrt_core import hrt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  byte_in,
    input  logic        msg_start,
    output hrt_result_t res
);

    phase_t           phase_reg, phase_next, cur_phase;
    logic [4:0]       spos_reg, spos_next, cur_spos;
    logic [3:0]       cand_reg, cand_next, cur_cand;
    logic [1:0]       found_reg, found_next, cur_found;
    logic [3:0]       npos_reg, npos_next, cur_npos;
    logic             nmatch_reg, nmatch_next, cur_nmatch;
    logic             skip_reg, skip_next, cur_skip;
    digits_t          digits_reg, digits_next, cur_digits;
    logic [LEN_W-1:0] len_reg, len_next, cur_len;
    logic [LEN_W-1:0] rem_reg, rem_next, cur_rem, rem_dec;
    err_t             error_reg, error_next, cur_error;
    logic [LEN_W-1:0] len_acc;
    logic [7:0]       low_c;
    logic             is_digit;

    assign low_c = lower_byte(byte_in);
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign rem_dec = (cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;

    hrt_len_acc u_len_acc (
        .len_in  (cur_len),
        .digit   (byte_in[3:0]),
        .len_out (len_acc)
    );

    always_comb begin
        cur_phase  = msg_start ? PH_VERSION : phase_reg;
        cur_spos   = msg_start ? 5'd0 : spos_reg;
        cur_cand   = msg_start ? 4'hF : cand_reg;
        cur_found  = msg_start ? STATUS_NONE : found_reg;
        cur_npos   = msg_start ? 4'd0 : npos_reg;
        cur_nmatch = msg_start ? 1'b1 : nmatch_reg;
        cur_skip   = msg_start ? 1'b0 : skip_reg;
        cur_digits = msg_start ? DA_IDLE : digits_reg;
        cur_len    = msg_start ? '0 : len_reg;
        cur_rem    = msg_start ? '0 : rem_reg;
        cur_error  = msg_start ? ERR_NONE : error_reg;

        phase_next  = cur_phase;
        spos_next   = cur_spos;
        cand_next   = cur_cand;
        found_next  = cur_found;
        npos_next   = cur_npos;
        nmatch_next = cur_nmatch;
        skip_next   = cur_skip;
        digits_next = cur_digits;
        len_next    = cur_len;
        rem_next    = cur_rem;
        error_next  = cur_error;

        res.kind      = K_IGNORED;
        res.char_out  = byte_in;
        res.head_done = 1'b0;
        res.body_last = 1'b0;

        unique case (cur_phase)
            PH_VERSION: begin
                if (byte_in == CH_SPACE) begin
                    res.kind = K_DELIM;
                    phase_next = PH_STATUS;
                end else if (byte_in == CH_CR) begin
                    res.kind = K_DELIM;
                    phase_next = PH_STATUS_LF;
                end else begin
                    res.kind = K_VERSION;
                end
            end
            PH_STATUS: begin
                if (byte_in == CH_CR) begin
                    res.kind = K_DELIM;
                    phase_next = PH_STATUS_LF;
                end else begin
                    res.kind = K_STATUS;
                    for (int i = 0; i < 4; i++) begin
                        if (!status_hit(2'(i), cur_spos, byte_in)) begin
                            cand_next[i] = 1'b0;
                        end
                    end
                    if (cur_spos != STAT_POS_MAX) begin
                        spos_next = cur_spos + 1'b1;
                    end
                end
            end
            PH_STATUS_LF: begin
                if (byte_in != CH_LF) begin
                    error_next = ERR_NO_LF;
                    phase_next = PH_ERROR;
                end else begin
                    priority if (cur_cand[0] && cur_spos == STAT_LEN0) begin
                        found_next = STATUS_OK;
                    end else if (cur_cand[1] && cur_spos == STAT_LEN1) begin
                        found_next = STATUS_OK;
                    end else if (cur_cand[2] && cur_spos == STAT_LEN2) begin
                        found_next = STATUS_NOT_FOUND;
                    end else if (cur_cand[3] && cur_spos == STAT_LEN3) begin
                        found_next = STATUS_SERVER_ERR;
                    end else begin
                        found_next = cur_found;
                    end
                    if (found_next == STATUS_NONE) begin
                        error_next = ERR_STATUS;
                        phase_next = PH_ERROR;
                    end else begin
                        res.kind = K_DELIM;
                        phase_next = PH_LINE_ST;
                    end
                end
            end
            PH_LINE_ST: begin
                if (byte_in == CH_CR) begin
                    res.kind = K_DELIM;
                    phase_next = PH_BLANK_LF;
                end else if (byte_in == CH_COLON) begin
                    error_next = ERR_NAME;
                    phase_next = PH_ERROR;
                end else begin
                    res.kind = K_NAME;
                    res.char_out = low_c;
                    nmatch_next = name_hit(4'd0, low_c);
                    npos_next = 4'd1;
                    phase_next = PH_NAME;
                end
            end
            PH_NAME: begin
                if (byte_in == CH_COLON) begin
                    res.kind = K_DELIM;
                    skip_next = 1'b1;
                    if (cur_nmatch && cur_npos == NAME_LEN) begin
                        len_next = '0;
                        digits_next = DA_WAIT;
                    end else begin
                        digits_next = DA_IDLE;
                    end
                    phase_next = PH_VALUE;
                end else if (byte_in == CH_CR) begin
                    res.kind = K_DELIM;
                    phase_next = PH_HEADER_LF;
                end else begin
                    res.kind = K_NAME;
                    res.char_out = low_c;
                    if (!name_hit(cur_npos, low_c)) begin
                        nmatch_next = 1'b0;
                    end
                    if (cur_npos != NAME_POS_MAX) begin
                        npos_next = cur_npos + 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                skip_next = 1'b0;
                if (cur_skip && byte_in == CH_SPACE) begin
                    res.kind = K_DELIM;
                end else if (byte_in == CH_CR) begin
                    res.kind = K_DELIM;
                    digits_next = DA_IDLE;
                    phase_next = PH_HEADER_LF;
                end else begin
                    res.kind = K_VALUE;
                    if (cur_digits != DA_IDLE) begin
                        if (is_digit) begin
                            len_next = len_acc;
                            digits_next = DA_IN;
                        end else if (!(cur_digits == DA_WAIT && byte_in == CH_SPACE)) begin
                            digits_next = DA_IDLE;
                        end
                    end
                end
            end
            PH_HEADER_LF: begin
                if (byte_in != CH_LF) begin
                    error_next = ERR_NO_LF;
                    phase_next = PH_ERROR;
                end else begin
                    res.kind = K_DELIM;
                    phase_next = PH_LINE_ST;
                end
            end
            PH_BLANK_LF: begin
                if (byte_in != CH_LF) begin
                    error_next = ERR_NO_LF;
                    phase_next = PH_ERROR;
                end else begin
                    res.kind = K_DELIM;
                    res.head_done = 1'b1;
                    rem_next = cur_len;
                    if (cur_len == '0) begin
                        res.body_last = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                res.kind = K_BODY;
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    res.body_last = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                res.kind = K_IGNORED;
            end
            PH_ERROR: begin
                res.kind = K_IGNORED;
            end
            default: begin
                res.kind = K_IGNORED;
            end
        endcase

        res.status = found_next;
        res.length = len_next;
        res.error  = error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_VERSION;
            spos_reg   <= 5'd0;
            cand_reg   <= 4'hF;
            found_reg  <= STATUS_NONE;
            npos_reg   <= 4'd0;
            nmatch_reg <= 1'b1;
            skip_reg   <= 1'b0;
            digits_reg <= DA_IDLE;
            len_reg    <= '0;
            rem_reg    <= '0;
            error_reg  <= ERR_NONE;
        end else if (step) begin
            phase_reg  <= phase_next;
            spos_reg   <= spos_next;
            cand_reg   <= cand_next;
            found_reg  <= found_next;
            npos_reg   <= npos_next;
            nmatch_reg <= nmatch_next;
            skip_reg   <= skip_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            error_reg  <= error_next;
        end
    end

    a_head_delim: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.head_done |-> res.kind == K_DELIM)
        else $error("head end not tagged as delimiter");

    a_err_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !msg_start && phase_reg == PH_ERROR |->
            res.kind == K_IGNORED && res.error == error_reg)
        else $error("byte after error not ignored");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg != ERR_NONE && !(step && msg_start) |=> error_reg == $past(error_reg))
        else $error("error code changed without restart");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.body_last |-> res.kind == K_BODY || res.head_done)
        else $error("body_last on a byte that ends neither head nor body");

endmodule

// ===== rtl/http_response_head_tokenizer_unit.sv =====
// Top level: input register, tokenizer core and result register with stream handshakes.
// Each s_ byte passes through the input register and then the result register before its m_ transfer.
// Throughput: one transfer per cycle while m_ does not stall; the core updates its state once per byte.
// Stalls on m_ hold both stages; s_tready drops only when both stages are full.
// Reset (aresetn low at a clock edge) clears both valid flags and all parser state.
// No memories, so no clearing pass after reset.
module http_response_head_tokenizer_unit import hrt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] byte_in
    input  logic                  s_tuser,   // [0] message_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] char_out, [9:8] status_code,
                                             // [41:10] content_length, [42] head_done,
                                             // [44:43] error_code, [47:45] zero
    output logic [2:0]            m_tuser,   // [2:0] byte_kind
    output logic                  m_tlast    // body_last
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    hrt_result_t out_reg;
    hrt_result_t res;
    logic        advance;
    logic        step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_byte_reg  <= '0;
            in_start_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    hrt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_in   (in_byte_reg),
        .msg_start (in_start_reg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_TDATA_USED){1'b0}}, out_reg.error, out_reg.head_done,
                       out_reg.length, out_reg.status, out_reg.char_out};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.body_last;

endmodule
